@@ src/lambda_token_scanner_macros.svh @@
// ----------------------------------------------------------------------------
// lambda_token_scanner_macros.svh
// Assertion helpers shared by the scanner RTL. Each use names its label and
// an antecedent and consequent; clocking and reset are fixed to clk and rst.
// ----------------------------------------------------------------------------
`ifndef LAMBDA_TOKEN_SCANNER_MACROS_SVH
`define LAMBDA_TOKEN_SCANNER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LTS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lambda_token_scanner: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define LTS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lambda_token_scanner: next-cycle check failed");

`endif

@@ src/lts_pkg.sv @@
// ----------------------------------------------------------------------------
// lts_pkg
// Shared types, character codes and token tags of the token scanner.
// ----------------------------------------------------------------------------
package lts_pkg;

  localparam int LTS_ROW_BITS     = 16;
  localparam int LTS_COL_BITS     = 12;
  localparam int LTS_PREFIX_CHARS = 8;
  localparam int LTS_QUEUE_DEPTH  = 2;

  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_ASSIGN  = 8'h3D;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_UNDER   = 8'h5F;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;

  // Keywords packed first character in the low byte.
  localparam logic [15:0] KW_IN     = 16'h6E69;
  localparam logic [23:0] KW_LAMBDA = 24'h6D616C;
  localparam logic [23:0] KW_LET    = 24'h74656C;

  typedef enum logic [3:0] {
    TAG_EOF          = 4'd0,
    TAG_ASSIGN       = 4'd1,
    TAG_DOT          = 4'd2,
    TAG_LPAREN       = 4'd3,
    TAG_RPAREN       = 4'd4,
    TAG_IN           = 4'd5,
    TAG_LAMBDA_KW    = 4'd6,
    TAG_LET          = 4'd7,
    TAG_IDENT        = 4'd8,
    TAG_BAD_CHAR     = 4'd9,
    TAG_LONE_SLASH   = 4'd10,
    TAG_OPEN_COMMENT = 4'd11
  } tag_t;

  typedef enum logic [3:0] {
    CLS_SPACE   = 4'd0,
    CLS_NEWLINE = 4'd1,
    CLS_LETTER  = 4'd2,
    CLS_DIGIT   = 4'd3,
    CLS_ASSIGN  = 4'd4,
    CLS_DOT     = 4'd5,
    CLS_LPAREN  = 4'd6,
    CLS_RPAREN  = 4'd7,
    CLS_SLASH   = 4'd8,
    CLS_STAR    = 4'd9,
    CLS_OTHER   = 4'd10
  } char_class_t;

  typedef struct packed {
    logic        eof;
    logic [7:0]  char_code;
    char_class_t cls;
  } scan_item_t;

  typedef struct packed {
    logic       valid;
    scan_item_t item;
  } item_beat_t;

  typedef struct packed {
    logic pend_valid;
    logic consume;
  } back_stat_t;

endpackage

@@ src/lts_front.sv @@
// ----------------------------------------------------------------------------
// lts_front
// Input side: accept characters and end-of-input markers, classify each byte
// and push the classified transaction into the queue.
// ----------------------------------------------------------------------------
module lts_front
  import lts_pkg::*;
(
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       func,
  input  logic [7:0] char_code,
  input  logic       q_ready,
  output item_beat_t push
);

  function automatic char_class_t classify(input logic [7:0] ch);
    char_class_t cls;
    if (ch == CH_NEWLINE) begin
      cls = CLS_NEWLINE;
    end else if (ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR)) begin
      cls = CLS_SPACE;
    end else if ((ch >= CH_LOWER_A && ch <= CH_LOWER_Z) ||
                 (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) || ch == CH_UNDER) begin
      cls = CLS_LETTER;
    end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
      cls = CLS_DIGIT;
    end else if (ch == CH_ASSIGN) begin
      cls = CLS_ASSIGN;
    end else if (ch == CH_DOT) begin
      cls = CLS_DOT;
    end else if (ch == CH_LPAREN) begin
      cls = CLS_LPAREN;
    end else if (ch == CH_RPAREN) begin
      cls = CLS_RPAREN;
    end else if (ch == CH_SLASH) begin
      cls = CLS_SLASH;
    end else if (ch == CH_STAR) begin
      cls = CLS_STAR;
    end else begin
      cls = CLS_OTHER;
    end
    return cls;
  endfunction

  assign in_ready            = q_ready;
  assign push.valid          = in_valid && q_ready;
  assign push.item.eof       = func;
  assign push.item.char_code = char_code;
  assign push.item.cls       = classify(char_code);

endmodule

@@ src/lts_queue.sv @@
// ----------------------------------------------------------------------------
// lts_queue
// Short FIFO between the classifier and the scanner back end.
// ----------------------------------------------------------------------------
module lts_queue
  import lts_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  item_beat_t push,
  output logic       ready,
  output item_beat_t head,
  input  logic       pop
);

  localparam int DEPTH = LTS_QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  scan_item_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign ready     = (count != CNT_W'(DEPTH));
  assign do_push   = push.valid && ready;
  assign head.valid = (count != '0);
  assign head.item = entries[rd_ptr];
  assign do_pop    = pop && head.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push.item;
    end
  end

endmodule

@@ src/lts_back.sv @@
// ----------------------------------------------------------------------------
// lts_back
// Scanner back end: mode register, cursor tracking, identifier capture and
// token output register with a one-deep slot for a second token.
// ----------------------------------------------------------------------------
module lts_back
  import lts_pkg::*;
#(
  parameter int ROW_BITS     = LTS_ROW_BITS,
  parameter int COL_BITS     = LTS_COL_BITS,
  parameter int PREFIX_CHARS = LTS_PREFIX_CHARS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  item_beat_t                head,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output tag_t                      out_tag,
  output logic [ROW_BITS-1:0]       out_begin_row,
  output logic [COL_BITS-1:0]       out_begin_col,
  output logic [ROW_BITS-1:0]       out_end_row,
  output logic [COL_BITS-1:0]       out_end_col,
  output logic [8*PREFIX_CHARS-1:0] out_prefix,
  output logic [7:0]                out_length,
  output logic                      out_last,
  output back_stat_t                stat
);

  localparam int PW = 8 * PREFIX_CHARS;

  typedef enum logic [5:0] {
    MODE_IDLE  = 6'b000001,
    MODE_IDENT = 6'b000010,
    MODE_SLASH = 6'b000100,
    MODE_LINE  = 6'b001000,
    MODE_BLOCK = 6'b010000,
    MODE_BSTAR = 6'b100000
  } mode_t;

  mode_t               mode, mode_next;
  logic [ROW_BITS-1:0] cursor_row, cursor_row_next;
  logic [COL_BITS-1:0] cursor_col, cursor_col_next;
  logic [ROW_BITS-1:0] start_row, start_row_next;
  logic [COL_BITS-1:0] start_col, start_col_next;
  logic [ROW_BITS-1:0] finish_row, finish_row_next;
  logic [COL_BITS-1:0] finish_col, finish_col_next;
  logic [PW-1:0]       name_prefix, name_prefix_next;
  logic [7:0]          name_length, name_length_next;

  logic                pend_valid;
  tag_t                pend_tag;
  logic [ROW_BITS-1:0] pend_row;
  logic [COL_BITS-1:0] pend_col;

  scan_item_t          it;
  logic                can_take;
  logic                load_pend;
  logic                load_new;

  // idle-scan results
  logic                idle_emit;
  tag_t                idle_tag;
  mode_t               idle_mode;

  // identifier token
  tag_t                name_tag;
  logic                name_is_kw;

  // first (flushed) token and second token of this transaction
  logic                flush_v;
  tag_t                flush_tag;
  logic [ROW_BITS-1:0] flush_br, flush_er;
  logic [COL_BITS-1:0] flush_bc, flush_ec;
  logic [PW-1:0]       flush_pre;
  logic [7:0]          flush_len;
  logic                sec_v;
  tag_t                sec_tag;
  logic                run_idle;

  assign it        = head.item;
  assign can_take  = !pend_valid && (!out_valid || out_ready);
  assign pop       = can_take && head.valid;
  assign load_pend = pend_valid && (!out_valid || out_ready);
  assign load_new  = pop && (flush_v || sec_v);

  assign stat.pend_valid = pend_valid;
  assign stat.consume    = pop;

  always_comb begin
    idle_emit = 1'b0;
    idle_tag  = TAG_BAD_CHAR;
    idle_mode = MODE_IDLE;
    unique case (it.cls)
      CLS_SPACE, CLS_NEWLINE: ;
      CLS_ASSIGN: begin idle_emit = 1'b1; idle_tag = TAG_ASSIGN; end
      CLS_DOT:    begin idle_emit = 1'b1; idle_tag = TAG_DOT;    end
      CLS_LPAREN: begin idle_emit = 1'b1; idle_tag = TAG_LPAREN; end
      CLS_RPAREN: begin idle_emit = 1'b1; idle_tag = TAG_RPAREN; end
      CLS_SLASH:  idle_mode = MODE_SLASH;
      CLS_LETTER: idle_mode = MODE_IDENT;
      default:    idle_emit = 1'b1;
    endcase
  end

  always_comb begin
    name_is_kw = 1'b1;
    if (name_length == 8'd2 && name_prefix == PW'(KW_IN)) begin
      name_tag = TAG_IN;
    end else if (name_length == 8'd3 && name_prefix == PW'(KW_LAMBDA)) begin
      name_tag = TAG_LAMBDA_KW;
    end else if (name_length == 8'd3 && name_prefix == PW'(KW_LET)) begin
      name_tag = TAG_LET;
    end else begin
      name_tag   = TAG_IDENT;
      name_is_kw = 1'b0;
    end
  end

  always_comb begin
    mode_next        = mode;
    start_row_next   = start_row;
    start_col_next   = start_col;
    finish_row_next  = cursor_row;
    finish_col_next  = cursor_col;
    name_prefix_next = name_prefix;
    name_length_next = name_length;
    cursor_row_next  = cursor_row;
    cursor_col_next  = cursor_col;
    flush_v          = 1'b0;
    flush_tag        = name_tag;
    flush_br         = start_row;
    flush_bc         = start_col;
    flush_er         = finish_row;
    flush_ec         = finish_col;
    flush_pre        = '0;
    flush_len        = '0;
    sec_v            = 1'b0;
    sec_tag          = idle_tag;
    run_idle         = 1'b0;

    // advance the cursor past this byte
    if (it.cls == CLS_NEWLINE) begin
      cursor_row_next = (&cursor_row) ? cursor_row : cursor_row + 1'b1;
      cursor_col_next = COL_BITS'(1);
    end else begin
      cursor_col_next = (&cursor_col) ? cursor_col : cursor_col + 1'b1;
    end

    if (it.eof) begin
      unique case (mode)
        MODE_IDENT: begin
          flush_v = 1'b1;
          if (!name_is_kw) begin
            flush_pre = name_prefix;
            flush_len = name_length;
          end
        end
        MODE_SLASH: begin
          flush_v   = 1'b1;
          flush_tag = TAG_LONE_SLASH;
          flush_er  = start_row;
          flush_ec  = start_col;
        end
        MODE_BLOCK, MODE_BSTAR: begin
          flush_v   = 1'b1;
          flush_tag = TAG_OPEN_COMMENT;
        end
        default: ;
      endcase
      sec_v            = 1'b1;
      sec_tag          = TAG_EOF;
      mode_next        = MODE_IDLE;
      cursor_row_next  = ROW_BITS'(1);
      cursor_col_next  = COL_BITS'(1);
      start_row_next   = ROW_BITS'(1);
      start_col_next   = COL_BITS'(1);
      finish_row_next  = ROW_BITS'(1);
      finish_col_next  = COL_BITS'(1);
      name_prefix_next = '0;
      name_length_next = '0;
    end else begin
      unique case (mode)
        MODE_IDENT: begin
          if (it.cls == CLS_LETTER || it.cls == CLS_DIGIT) begin
            for (int i = 0; i < PREFIX_CHARS; i++) begin
              if (name_length == 8'(i)) begin
                name_prefix_next[8*i +: 8] = it.char_code;
              end
            end
            name_length_next = (&name_length) ? name_length : name_length + 1'b1;
          end else begin
            flush_v = 1'b1;
            if (!name_is_kw) begin
              flush_pre = name_prefix;
              flush_len = name_length;
            end
            name_prefix_next = '0;
            name_length_next = '0;
            run_idle         = 1'b1;
          end
        end
        MODE_SLASH: begin
          if (it.cls == CLS_STAR) begin
            mode_next = MODE_BLOCK;
          end else if (it.cls == CLS_SLASH) begin
            mode_next = MODE_LINE;
          end else begin
            flush_v   = 1'b1;
            flush_tag = TAG_LONE_SLASH;
            flush_er  = start_row;
            flush_ec  = start_col;
            run_idle  = 1'b1;
          end
        end
        MODE_LINE: begin
          if (it.cls == CLS_NEWLINE) mode_next = MODE_IDLE;
        end
        MODE_BLOCK: begin
          if (it.cls == CLS_STAR) mode_next = MODE_BSTAR;
        end
        MODE_BSTAR: begin
          if (it.cls == CLS_SLASH) begin
            mode_next = MODE_IDLE;
          end else if (it.cls != CLS_STAR) begin
            mode_next = MODE_BLOCK;
          end
        end
        default: run_idle = 1'b1;
      endcase

      if (run_idle) begin
        mode_next      = idle_mode;
        start_row_next = cursor_row;
        start_col_next = cursor_col;
        sec_v          = idle_emit;
        if (it.cls == CLS_LETTER) begin
          name_prefix_next = PW'(it.char_code);
          name_length_next = 8'd1;
        end
      end
    end
  end

  // scanner state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_IDLE;
      cursor_row  <= ROW_BITS'(1);
      cursor_col  <= COL_BITS'(1);
      start_row   <= ROW_BITS'(1);
      start_col   <= COL_BITS'(1);
      finish_row  <= ROW_BITS'(1);
      finish_col  <= COL_BITS'(1);
      name_prefix <= '0;
      name_length <= '0;
    end else if (pop) begin
      mode        <= mode_next;
      cursor_row  <= cursor_row_next;
      cursor_col  <= cursor_col_next;
      start_row   <= start_row_next;
      start_col   <= start_col_next;
      finish_row  <= finish_row_next;
      finish_col  <= finish_col_next;
      name_prefix <= name_prefix_next;
      name_length <= name_length_next;
    end
  end

  // output handshake control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (load_pend) begin
      out_valid  <= 1'b1;
      pend_valid <= 1'b0;
    end else if (load_new) begin
      out_valid  <= 1'b1;
      pend_valid <= flush_v && sec_v;
    end else if (out_ready) begin
      out_valid  <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load_pend) begin
      out_tag       <= pend_tag;
      out_begin_row <= pend_row;
      out_begin_col <= pend_col;
      out_end_row   <= pend_row;
      out_end_col   <= pend_col;
      out_prefix    <= '0;
      out_length    <= '0;
      out_last      <= 1'b1;
    end else if (load_new) begin
      if (flush_v) begin
        out_tag       <= flush_tag;
        out_begin_row <= flush_br;
        out_begin_col <= flush_bc;
        out_end_row   <= flush_er;
        out_end_col   <= flush_ec;
        out_prefix    <= flush_pre;
        out_length    <= flush_len;
      end else begin
        out_tag       <= sec_tag;
        out_begin_row <= cursor_row;
        out_begin_col <= cursor_col;
        out_end_row   <= cursor_row;
        out_end_col   <= cursor_col;
        out_prefix    <= '0;
        out_length    <= '0;
      end
      out_last <= !(flush_v && sec_v);
      pend_tag <= sec_tag;
      pend_row <= cursor_row;
      pend_col <= cursor_col;
    end
  end

endmodule

@@ src/lambda_token_scanner.sv @@
// ----------------------------------------------------------------------------
// lambda_token_scanner
// Streaming lexer for a small lambda language: one byte or end-of-input
// marker in, tokens with begin/end positions out.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake             Payload
//  -------  ---------  --------------------  -----------------------------------
//  in       sink       in_valid / in_ready   func, char_code
//  out      source     out_valid / out_ready token_tag, begin_row, begin_col,
//                                            end_row, end_col, ident_prefix,
//                                            ident_length, last
//
//  One input transaction per cycle while in_ready is high; a transaction
//  that yields two tokens holds the back end until both have left, since
//  the output register sends one token per cycle while out_ready is high.
//  An accepted byte passes through the queue, and the token it completes
//  is then loaded into the output register. While a token waits, the
//  two-entry queue takes two more transactions before in_ready drops.
//  rst is synchronous and clears mode, cursor and handshake state; no
//  clearing pass follows.
//
// ----------------------------------------------------------------------------
`include "lambda_token_scanner_macros.svh"

module lambda_token_scanner
  import lts_pkg::*;
#(
  parameter int ROW_BITS     = LTS_ROW_BITS,
  parameter int COL_BITS     = LTS_COL_BITS,
  parameter int PREFIX_CHARS = LTS_PREFIX_CHARS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      func,
  input  logic [7:0]                char_code,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [3:0]                token_tag,
  output logic [ROW_BITS-1:0]       begin_row,
  output logic [COL_BITS-1:0]       begin_col,
  output logic [ROW_BITS-1:0]       end_row,
  output logic [COL_BITS-1:0]       end_col,
  output logic [8*PREFIX_CHARS-1:0] ident_prefix,
  output logic [7:0]                ident_length,
  output logic                      last
);

  item_beat_t push;
  item_beat_t head;
  logic       q_ready;
  logic       pop;
  tag_t       tag;
  back_stat_t stat;

  // Classify each accepted byte and push it into the queue.
  lts_front u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .char_code (char_code),
    .q_ready   (q_ready),
    .push      (push)
  );

  // Decouple the input stream from token output stalls.
  lts_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .ready (q_ready),
    .head  (head),
    .pop   (pop)
  );

  // Run the scanner mode machine and register the tokens.
  lts_back #(
    .ROW_BITS     (ROW_BITS),
    .COL_BITS     (COL_BITS),
    .PREFIX_CHARS (PREFIX_CHARS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_tag       (tag),
    .out_begin_row (begin_row),
    .out_begin_col (begin_col),
    .out_end_row   (end_row),
    .out_end_col   (end_col),
    .out_prefix    (ident_prefix),
    .out_length    (ident_length),
    .out_last      (last),
    .stat          (stat)
  );

  assign token_tag = tag;

  // A second token never waits without a first one in the output register.
  `LTS_ASSERT_SAME(a_pend_needs_out, stat.pend_valid, out_valid)
  // The held second token closes its transaction.
  `LTS_ASSERT_NEXT(a_pend_is_last, out_valid && out_ready && stat.pend_valid, out_valid && last)
  // End of input always yields a token.
  `LTS_ASSERT_NEXT(a_eof_emits, stat.consume && head.item.eof, out_valid)
  // Only identifiers carry a length.
  `LTS_ASSERT_SAME(a_len_ident_only, out_valid && token_tag != TAG_IDENT, ident_length == 8'd0)

endmodule

@@ tb/token_stream_checker.sv @@
// ----------------------------------------------------------------------------
// token_stream_checker
// Watches both channels of the token scanner, predicts the token stream from
// each accepted input transaction and compares every output transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module token_stream_checker
  import lts_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic                        func,
  input  logic [7:0]                  char_code,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [3:0]                  token_tag,
  input  logic [LTS_ROW_BITS-1:0]     begin_row,
  input  logic [LTS_COL_BITS-1:0]     begin_col,
  input  logic [LTS_ROW_BITS-1:0]     end_row,
  input  logic [LTS_COL_BITS-1:0]     end_col,
  input  logic [8*LTS_PREFIX_CHARS-1:0] ident_prefix,
  input  logic [7:0]                  ident_length,
  input  logic                        last,
  output int                          mismatches,
  output int                          tokens_checked,
  output int                          pending_tokens
);

  typedef logic [LTS_ROW_BITS-1:0]       row_t;
  typedef logic [LTS_COL_BITS-1:0]       col_t;
  typedef logic [8*LTS_PREFIX_CHARS-1:0] prefix_t;

  localparam row_t ROW_TOP = '1;
  localparam col_t COL_TOP = '1;

  typedef enum logic [2:0] {
    SCAN_IDLE       = 3'd0,
    SCAN_NAME       = 3'd1,
    SCAN_SLASH      = 3'd2,
    SCAN_LINE_CMT   = 3'd3,
    SCAN_BLOCK_CMT  = 3'd4,
    SCAN_BLOCK_STAR = 3'd5
  } scan_mode_t;

  typedef struct packed {
    tag_t       tag;
    row_t       begin_row;
    col_t       begin_col;
    row_t       end_row;
    col_t       end_col;
    prefix_t    prefix;
    logic [7:0] name_len;
    logic       last;
  } token_t;

  scan_mode_t mode;
  row_t       cur_row, tok_row, prev_row;
  col_t       cur_col, tok_col, prev_col;
  prefix_t    name_text;
  logic [7:0] name_count;
  token_t     expected_tokens[$];
  int         err_n;
  int         seen_n;

  function automatic bit is_letter(input logic [7:0] c);
    return (c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
           c == CH_UNDER;
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic string token_text(input token_t t);
    return $sformatf("tag=%0d begin=%0d:%0d end=%0d:%0d prefix=%h len=%0d last=%0b",
                     t.tag, t.begin_row, t.begin_col, t.end_row, t.end_col,
                     t.prefix, t.name_len, t.last);
  endfunction

  task automatic add_token(input tag_t tag, input row_t br, input col_t bc,
                           input row_t er, input col_t ec, input prefix_t pre,
                           input logic [7:0] len);
    token_t t;
    t.tag       = tag;
    t.begin_row = br;
    t.begin_col = bc;
    t.end_row   = er;
    t.end_col   = ec;
    t.prefix    = pre;
    t.name_len  = len;
    t.last      = 1'b0;
    expected_tokens.push_back(t);
  endtask

  // Consume one byte: remember its position, then step the cursor.
  task automatic move_cursor(input logic [7:0] c);
    prev_row = cur_row;
    prev_col = cur_col;
    if (c == CH_NEWLINE) begin
      if (cur_row != ROW_TOP) cur_row++;
      cur_col = 1;
    end else if (cur_col != COL_TOP) begin
      cur_col++;
    end
  endtask

  task automatic flush_name;
    tag_t tag;
    tag = TAG_IDENT;
    if (name_count == 2 && name_text == prefix_t'(KW_IN)) tag = TAG_IN;
    else if (name_count == 3 && name_text == prefix_t'(KW_LAMBDA)) tag = TAG_LAMBDA_KW;
    else if (name_count == 3 && name_text == prefix_t'(KW_LET)) tag = TAG_LET;
    if (tag == TAG_IDENT)
      add_token(tag, tok_row, tok_col, prev_row, prev_col, name_text, name_count);
    else
      add_token(tag, tok_row, tok_col, prev_row, prev_col, '0, '0);
  endtask

  task automatic clear_scan;
    mode       = SCAN_IDLE;
    cur_row    = 1;
    cur_col    = 1;
    tok_row    = 1;
    tok_col    = 1;
    prev_row   = 1;
    prev_col   = 1;
    name_text  = '0;
    name_count = '0;
  endtask

  // Byte seen between tokens.
  task automatic scan_fresh(input logic [7:0] c);
    tag_t tag;
    bit   single;
    tag    = TAG_EOF;
    single = 1'b1;
    if (is_blank(c)) begin
      move_cursor(c);
      return;
    end
    case (c)
      CH_ASSIGN: tag = TAG_ASSIGN;
      CH_DOT:    tag = TAG_DOT;
      CH_LPAREN: tag = TAG_LPAREN;
      CH_RPAREN: tag = TAG_RPAREN;
      default:   single = 1'b0;
    endcase
    if (single) begin
      add_token(tag, cur_row, cur_col, cur_row, cur_col, '0, '0);
      move_cursor(c);
      return;
    end
    tok_row = cur_row;
    tok_col = cur_col;
    if (c == CH_SLASH) begin
      mode = SCAN_SLASH;
    end else if (is_letter(c)) begin
      name_text  = prefix_t'(c);
      name_count = 1;
      mode       = SCAN_NAME;
    end else begin
      add_token(TAG_BAD_CHAR, cur_row, cur_col, cur_row, cur_col, '0, '0);
    end
    move_cursor(c);
  endtask

  // Predict the tokens of one input transaction and flag the final one.
  task automatic lex_item(input logic eof, input logic [7:0] c);
    int     count0;
    token_t t;
    count0 = expected_tokens.size();
    if (eof) begin
      case (mode)
        SCAN_NAME:  flush_name();
        SCAN_SLASH: add_token(TAG_LONE_SLASH, tok_row, tok_col, tok_row, tok_col, '0, '0);
        SCAN_BLOCK_CMT, SCAN_BLOCK_STAR:
          add_token(TAG_OPEN_COMMENT, tok_row, tok_col, prev_row, prev_col, '0, '0);
        default: ;
      endcase
      add_token(TAG_EOF, cur_row, cur_col, cur_row, cur_col, '0, '0);
      clear_scan();
    end else begin
      case (mode)
        SCAN_NAME: begin
          if (is_letter(c) || (c >= CH_ZERO && c <= CH_NINE)) begin
            if (name_count < LTS_PREFIX_CHARS) name_text |= prefix_t'(c) << (8 * name_count);
            if (name_count != 8'hFF) name_count++;
            move_cursor(c);
          end else begin
            flush_name();
            mode       = SCAN_IDLE;
            name_text  = '0;
            name_count = '0;
            scan_fresh(c);
          end
        end
        SCAN_SLASH: begin
          if (c == CH_STAR) begin
            mode = SCAN_BLOCK_CMT;
            move_cursor(c);
          end else if (c == CH_SLASH) begin
            mode = SCAN_LINE_CMT;
            move_cursor(c);
          end else begin
            add_token(TAG_LONE_SLASH, tok_row, tok_col, tok_row, tok_col, '0, '0);
            mode = SCAN_IDLE;
            scan_fresh(c);
          end
        end
        SCAN_LINE_CMT: begin
          if (c == CH_NEWLINE) mode = SCAN_IDLE;
          move_cursor(c);
        end
        SCAN_BLOCK_CMT: begin
          if (c == CH_STAR) mode = SCAN_BLOCK_STAR;
          move_cursor(c);
        end
        SCAN_BLOCK_STAR: begin
          if (c == CH_SLASH) mode = SCAN_IDLE;
          else if (c != CH_STAR) mode = SCAN_BLOCK_CMT;
          move_cursor(c);
        end
        default: begin
          mode = SCAN_IDLE;
          scan_fresh(c);
        end
      endcase
    end
    if (expected_tokens.size() > count0) begin
      t      = expected_tokens.pop_back();
      t.last = 1'b1;
      expected_tokens.push_back(t);
    end
  endtask

  always @(posedge clk) begin : watch
    token_t got;
    token_t want;
    if (rst) begin
      clear_scan();
      expected_tokens.delete();
      err_n  = 0;
      seen_n = 0;
    end else begin
      if (in_valid && in_ready) lex_item(func, char_code);
      if (out_valid && out_ready) begin
        got.tag       = tag_t'(token_tag);
        got.begin_row = begin_row;
        got.begin_col = begin_col;
        got.end_row   = end_row;
        got.end_col   = end_col;
        got.prefix    = ident_prefix;
        got.name_len  = ident_length;
        got.last      = last;
        seen_n++;
        if (expected_tokens.size() == 0) begin
          err_n++;
          if (err_n <= 10) $display("[%0t] unexpected token: %s", $realtime, token_text(got));
        end else begin
          want = expected_tokens.pop_front();
          if (got !== want) begin
            err_n++;
            if (err_n <= 10) begin
              $display("[%0t] token mismatch", $realtime);
              $display("  expected %s", token_text(want));
              $display("  actual   %s", token_text(got));
            end
          end
        end
      end
    end
    mismatches     <= err_n;
    tokens_checked <= seen_n;
    pending_tokens <= expected_tokens.size();
  end

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Feeds the token scanner a character stream: hand-picked text for every
// token kind, comment form and error, a long identifier whose length count
// saturates, then a random mix of well-formed fragments and noise.
// Both channels idle at random; a token stream checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import lts_pkg::*;

  // Cycle limit for the watchdog; a correct run ends well before it.
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES  = 400;
  localparam int RANDOM_ITEMS = 110;

  typedef enum int {
    FRAG_KEYWORD,
    FRAG_NAME,
    FRAG_PUNCT,
    FRAG_BLANK,
    FRAG_LINE_CMT,
    FRAG_BLOCK_CMT,
    FRAG_SLASH,
    FRAG_NOISE,
    FRAG_EOF
  } fragment_t;

  logic                          clk;
  logic                          rst       = 1'b1;
  logic                          in_valid  = 1'b0;
  logic                          func      = 1'b0;
  logic [7:0]                    char_code = 8'h00;
  logic                          out_ready = 1'b0;
  logic                          in_ready;
  logic                          out_valid;
  logic [3:0]                    token_tag;
  logic [LTS_ROW_BITS-1:0]       begin_row;
  logic [LTS_COL_BITS-1:0]       begin_col;
  logic [LTS_ROW_BITS-1:0]       end_row;
  logic [LTS_COL_BITS-1:0]       end_col;
  logic [8*LTS_PREFIX_CHARS-1:0] ident_prefix;
  logic [7:0]                    ident_length;
  logic                          last;

  int mismatches;
  int tokens_checked;
  int pending_tokens;

  // Stimulus bookkeeping and the knobs shared by the two driving processes.
  int items_sent   = 0;
  int markers_sent = 0;
  int hold_offs    = 0;
  int cycles       = 0;
  bit quiet_send   = 1'b0;
  bit quiet_recv   = 1'b0;
  bit hold_request = 1'b0;

  lambda_token_scanner uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .func         (func),
    .char_code    (char_code),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .token_tag    (token_tag),
    .begin_row    (begin_row),
    .begin_col    (begin_col),
    .end_row      (end_row),
    .end_col      (end_col),
    .ident_prefix (ident_prefix),
    .ident_length (ident_length),
    .last         (last)
  );

  token_stream_checker token_watch (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .func           (func),
    .char_code      (char_code),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .token_tag      (token_tag),
    .begin_row      (begin_row),
    .begin_col      (begin_col),
    .end_row        (end_row),
    .end_col        (end_col),
    .ident_prefix   (ident_prefix),
    .ident_length   (ident_length),
    .last           (last),
    .mismatches     (mismatches),
    .tokens_checked (tokens_checked),
    .pending_tokens (pending_tokens)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost token ends the run here.
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // Token receiver: draw a stall per transaction, then hold ready until the
  // transaction completes. A pending hold-off request replaces one stall with
  // a long stretch so the block backs up into its input.
  initial begin : token_sink
    int stall;
    forever begin
      stall = quiet_recv ? 0 : $urandom_range(0, 14);
      if (hold_request) begin
        stall        = HOLD_CYCLES;
        hold_request = 1'b0;
        hold_offs++;
      end
      if (stall > 0) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Offer one input transaction after a random gap and hold it until taken.
  task automatic send_byte(input logic eof, input logic [7:0] c);
    int gap;
    gap = quiet_send ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    func      <= eof;
    char_code <= c;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (eof) markers_sent++;
  endtask

  task automatic send_marker;
    send_byte(1'b1, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(1'b0, s[i]);
  endtask

  task automatic send_run(input logic [7:0] c, input int n);
    repeat (n) send_byte(1'b0, c);
  endtask

  // Keyword constants are packed first character in the low byte.
  task automatic send_word(input logic [23:0] w, input int n);
    for (int i = 0; i < n; i++) send_byte(1'b0, w[8*i +: 8]);
  endtask

  function automatic logic [7:0] pick_name_char(input bit lead);
    int r;
    r = $urandom_range(0, lead ? 52 : 62);
    if (r < 26) return CH_LOWER_A + 8'(r);
    if (r < 52) return CH_UPPER_A + 8'(r - 26);
    if (r == 52) return CH_UNDER;
    return CH_ZERO + 8'(r - 53);
  endfunction

  task automatic send_name;
    int len;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
    send_byte(1'b0, pick_name_char(1'b1));
    repeat (len - 1) send_byte(1'b0, pick_name_char(1'b0));
  endtask

  task automatic send_keyword;
    case ($urandom_range(0, 2))
      0:       send_word(24'(KW_IN), 2);
      1:       send_word(KW_LAMBDA, 3);
      default: send_word(KW_LET, 3);
    endcase
  endtask

  task automatic send_punct;
    case ($urandom_range(0, 3))
      0:       send_byte(1'b0, CH_ASSIGN);
      1:       send_byte(1'b0, CH_DOT);
      2:       send_byte(1'b0, CH_LPAREN);
      default: send_byte(1'b0, CH_RPAREN);
    endcase
  endtask

  task automatic send_blank;
    int r;
    r = $urandom_range(0, 6);
    send_byte(1'b0, (r > 4) ? CH_SPACE : CH_TAB + 8'(r));
  endtask

  task automatic send_line_comment;
    send_word({8'h00, CH_SLASH, CH_SLASH}, 2);
    repeat ($urandom_range(0, 8)) send_byte(1'b0, 8'($urandom_range(32, 126)));
    send_byte(1'b0, CH_NEWLINE);
  endtask

  // Body mixes stars, slashes and newlines; close with one or more stars.
  task automatic send_block_comment;
    int r;
    send_word({8'h00, CH_STAR, CH_SLASH}, 2);
    repeat ($urandom_range(0, 8)) begin
      r = $urandom_range(0, 5);
      case (r)
        0:       send_byte(1'b0, CH_STAR);
        1:       send_byte(1'b0, CH_SLASH);
        2:       send_byte(1'b0, CH_NEWLINE);
        3:       send_byte(1'b0, CH_SPACE);
        default: send_byte(1'b0, pick_name_char(1'b0));
      endcase
    end
    send_run(CH_STAR, $urandom_range(1, 3));
    send_byte(1'b0, CH_SLASH);
  endtask

  function automatic fragment_t pick_fragment;
    int r;
    r = $urandom_range(0, 99);
    if (r < 14) return FRAG_KEYWORD;
    if (r < 34) return FRAG_NAME;
    if (r < 54) return FRAG_PUNCT;
    if (r < 68) return FRAG_BLANK;
    if (r < 74) return FRAG_LINE_CMT;
    if (r < 80) return FRAG_BLOCK_CMT;
    if (r < 85) return FRAG_SLASH;
    if (r < 96) return FRAG_NOISE;
    return FRAG_EOF;
  endfunction

  initial begin : stimulus
    int        base;
    bit        pressed;
    fragment_t frag;

    // Hold reset, then release it on a falling edge.
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed text: punctuation, keywords and near-keywords, identifiers
    // past the prefix width, error bytes, slash and comment forms.
    send_text("=.()");
    send_word(24'(KW_IN), 2);
    send_text(" ");
    send_word(KW_LAMBDA, 3);
    send_text("\t");
    send_word(KW_LET, 3);
    send_text(" lets x_9Z abcdefghijk\n");
    send_byte(1'b0, 8'h00);
    send_byte(1'b0, 8'h80);
    send_byte(1'b0, 8'hFF);
    send_text("#*7");
    send_text("/ /x//c\n/* a **/ /***/");

    // End markers in every scan state: pending identifier, lone slash,
    // open comment, comment after a star, line comment and between tokens.
    send_text("ab");
    send_marker();
    send_text("/");
    send_marker();
    send_text("/* x");
    send_marker();
    send_text("/**");
    send_marker();
    send_text("// z");
    send_marker();
    send_marker();

    // Long identifier at full rate: its length count saturates at 255.
    quiet_send = 1'b1;
    quiet_recv = 1'b1;
    send_run(CH_LOWER_A + 8'd16, 260);
    send_text(" ");
    quiet_send = 1'b0;
    quiet_recv = 1'b0;

    // Random mix: mostly well-formed fragments, some noise and markers.
    // Partway through, stall the receiver while a burst keeps arriving.
    base    = items_sent;
    pressed = 1'b0;
    while (items_sent - base < RANDOM_ITEMS) begin
      if ($urandom_range(0, 15) == 0) quiet_send = ~quiet_send;
      if ($urandom_range(0, 15) == 0) quiet_recv = ~quiet_recv;
      if (!pressed && items_sent - base > RANDOM_ITEMS / 2) begin
        pressed      = 1'b1;
        hold_request = 1'b1;
        quiet_send   = 1'b1;
        send_run(CH_RPAREN, 40);
      end
      frag = pick_fragment();
      case (frag)
        FRAG_KEYWORD:   send_keyword();
        FRAG_NAME:      send_name();
        FRAG_PUNCT:     send_punct();
        FRAG_BLANK:     send_blank();
        FRAG_LINE_CMT:  send_line_comment();
        FRAG_BLOCK_CMT: send_block_comment();
        FRAG_SLASH:     send_byte(1'b0, CH_SLASH);
        FRAG_NOISE:     send_byte(1'b0, 8'($urandom_range(0, 255)));
        default:        send_marker();
      endcase
    end

    // Close the stream so the last token is always flushed, then drop valid.
    send_marker();
    @(negedge clk);
    in_valid <= 1'b0;

    // Drain: wait for every predicted token, then a few more cycles.
    @(posedge clk);
    while (pending_tokens != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Scanned %0d input transactions (%0d end markers); %0d tokens compared.",
             items_sent, markers_sent, tokens_checked);
    $display("Stream mixed comments, error bytes, a saturated name length and %0d long stall(s).",
             hold_offs);
    if (mismatches == 0 && pending_tokens == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
